@@ hdl/crc_checked_response_deframer_core_macros.svh @@
// assertion macros used by the deframer rtl
`ifndef CRC_CHECKED_RESPONSE_DEFRAMER_CORE_MACROS_SVH
`define CRC_CHECKED_RESPONSE_DEFRAMER_CORE_MACROS_SVH

// plain property, clocked on clk_i, off while rst_ni is low
`define CRCDF_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// implication: when ante holds, cons holds in the same cycle
`define CRCDF_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

@@ hdl/crcdf_pkg.sv @@
`default_nettype none

package crcdf_pkg;

  // default frame limit in bytes before the carriage return
  localparam int unsigned MaxFrameDefault = 256;

  // framing characters
  localparam logic [7:0] CharOpen = 8'h28;
  localparam logic [7:0] CharCr   = 8'h0d;
  localparam logic [7:0] CharLf   = 8'h0a;

  // end-of-frame status codes
  typedef enum logic [2:0] {
    StOk       = 3'd0,
    StBadCrc   = 3'd1,
    StBadStart = 3'd2,
    StTooShort = 3'd3,
    StOverflow = 3'd4
  } status_e;

  // crc-16 poly 0x1021, one entry per nibble value
  localparam logic [15:0] NibTable [16] = '{
    16'h0000, 16'h1021, 16'h2042, 16'h3063, 16'h4084, 16'h50a5, 16'h60c6, 16'h70e7,
    16'h8108, 16'h9129, 16'ha14a, 16'hb16b, 16'hc18c, 16'hd1ad, 16'he1ce, 16'hf1ef
  };

  // one nibble of crc update, msb first
  function automatic logic [15:0] crc_nibble(logic [15:0] crc, logic [3:0] nib);
    logic [3:0] idx;
    idx = crc[15:12] ^ nib;
    return {crc[11:0], 4'h0} ^ NibTable[idx];
  endfunction

  // bump a crc byte that would collide with a framing character
  function automatic logic [7:0] escape_byte(logic [7:0] b);
    logic [7:0] r;
    r = b;
    if (b == CharOpen || b == CharCr || b == CharLf) begin
      r = b + 8'd1;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ hdl/crcdf_crc_step.sv @@
`default_nettype none

// crc-16 update over one byte, two table nibbles, high nibble first
module crcdf_crc_step (
  input  wire logic [15:0] crc_i,
  input  wire logic [7:0]  data_i,
  output logic      [15:0] crc_o
);

  logic [15:0] crc_mid;

  // high nibble then low nibble
  always_comb begin
    crc_mid = crcdf_pkg::crc_nibble(crc_i, data_i[7:4]);
    crc_o   = crcdf_pkg::crc_nibble(crc_mid, data_i[3:0]);
  end

endmodule

`default_nettype wire

@@ hdl/crc_checked_response_deframer_core.sv @@
// channel   dir  handshake                 payload
// rx        in   in_valid_i / in_stall_o   rx_byte_i[7:0]
// result    out  out_valid_o / out_stall_i payload_byte_o, is_end_o,
//                                          frame_status_o, payload_length_o
//
// one request accepted per cycle when the result side keeps up
// each request passes the input register, then frame logic into the result register
// the crc byte step is combinational (two nibble table lookups)
// reset clears the frame state (crc, delay line, start flag, byte counter) and both valid flags
// a stalled result holds; one more request waits in the input register meanwhile
`default_nettype none
`include "crc_checked_response_deframer_core_macros.svh"

module crc_checked_response_deframer_core #(
  parameter int unsigned MAX_FRAME = crcdf_pkg::MaxFrameDefault
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] rx_byte_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      payload_byte_o,
  output logic            is_end_o,
  output logic [2:0]      frame_status_o,
  output logic [8:0]      payload_length_o
);

  localparam int unsigned CntW = $clog2(MAX_FRAME + 2);
  localparam logic [CntW-1:0] MaxCnt   = CntW'(MAX_FRAME);
  localparam logic [CntW-1:0] MaxCntP1 = CntW'(MAX_FRAME + 1);
  localparam logic [CntW-1:0] MinLen   = CntW'(3);
  localparam logic [CntW-1:0] StartPos = CntW'(2);

  // input register
  logic       s1_valid_q, s1_valid_d;
  logic [7:0] s1_byte_q;

  // frame state
  logic [15:0]     crc_q, crc_d;
  logic [7:0]      older_q, older_d;
  logic [7:0]      newer_q, newer_d;
  logic            start_ok_q, start_ok_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  // result register
  logic       out_valid_q, out_valid_d;
  logic [7:0] out_byte_q;
  logic       out_end_q;
  logic [2:0] out_status_q;
  logic [8:0] out_len_q;

  // result of the current request
  logic                res_valid;
  logic [7:0]          res_byte;
  logic                res_end;
  crcdf_pkg::status_e  res_status;
  logic [8:0]          res_len;

  logic            consume;
  logic            in_acc;
  logic [15:0]     crc_next;
  logic [15:0]     crc_want;
  logic [CntW-1:0] limited;
  logic [CntW-1:0] len_full;

  // handshake
  assign consume    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !consume;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_acc) begin
      s1_valid_d = 1'b1;
    end else if (consume) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_byte_q <= rx_byte_i;
    end
  end

  // crc over the byte leaving the delay line
  crcdf_crc_step u_crc_step (
    .crc_i  (crc_q),
    .data_i (older_q),
    .crc_o  (crc_next)
  );

  // expected crc with framing characters escaped, and payload length
  always_comb begin
    crc_want = {crcdf_pkg::escape_byte(crc_q[15:8]), crcdf_pkg::escape_byte(crc_q[7:0])};
    limited  = (cnt_q > MaxCnt) ? MaxCnt : cnt_q;
    len_full = (start_ok_q && limited > MinLen) ? (limited - MinLen) : '0;
  end

  // frame logic
  always_comb begin
    crc_d      = crc_q;
    older_d    = older_q;
    newer_d    = newer_q;
    start_ok_d = start_ok_q;
    cnt_d      = cnt_q;
    res_valid  = 1'b0;
    res_byte   = '0;
    res_end    = 1'b0;
    res_status = crcdf_pkg::StOk;
    res_len    = '0;
    if (consume) begin
      if (s1_byte_q == crcdf_pkg::CharCr) begin
        // end of frame: status, then back to an empty frame
        res_valid = 1'b1;
        res_end   = 1'b1;
        res_len   = 9'(len_full);
        priority if (cnt_q > MaxCnt) begin
          res_status = crcdf_pkg::StOverflow;
        end else if (cnt_q < MinLen) begin
          res_status = crcdf_pkg::StTooShort;
        end else if (crc_want != {older_q, newer_q}) begin
          res_status = crcdf_pkg::StBadCrc;
        end else if (!start_ok_q) begin
          res_status = crcdf_pkg::StBadStart;
        end else begin
          res_status = crcdf_pkg::StOk;
        end
        crc_d      = '0;
        older_d    = '0;
        newer_d    = '0;
        start_ok_d = 1'b0;
        cnt_d      = '0;
      end else if (cnt_q <= MaxCnt) begin
        // ordinary byte: count, crc the leaving byte, shift the delay line
        cnt_d = cnt_q + 1'b1;
        if (cnt_q < MaxCnt && cnt_q >= StartPos) begin
          crc_d = crc_next;
          if (cnt_q == StartPos) begin
            start_ok_d = (older_q == crcdf_pkg::CharOpen);
          end else if (start_ok_q) begin
            res_valid = 1'b1;
            res_byte  = older_q;
          end
        end
        older_d = newer_q;
        newer_d = s1_byte_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q      <= '0;
      older_q    <= '0;
      newer_q    <= '0;
      start_ok_q <= 1'b0;
      cnt_q      <= '0;
    end else begin
      crc_q      <= crc_d;
      older_q    <= older_d;
      newer_q    <= newer_d;
      start_ok_q <= start_ok_d;
      cnt_q      <= cnt_d;
    end
  end

  // result register
  always_comb begin
    out_valid_d = out_valid_q;
    if (consume) begin
      out_valid_d = res_valid;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (consume && res_valid) begin
      out_byte_q   <= res_byte;
      out_end_q    <= res_end;
      out_status_q <= res_status;
      out_len_q    <= res_len;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign payload_byte_o   = out_byte_q;
  assign is_end_o         = out_end_q;
  assign frame_status_o   = out_status_q;
  assign payload_length_o = out_len_q;

  // checks
  `CRCDF_ASSERT(a_cnt_bounded, cnt_q <= MaxCntP1, "frame byte count past saturation")
  `CRCDF_ASSERT_IMP(a_payload_clean, out_valid_o && !is_end_o,
    frame_status_o == crcdf_pkg::StOk && payload_length_o == 9'd0, "payload result carries status")
  `CRCDF_ASSERT_IMP(a_end_clears, $past(consume) && $past(s1_byte_q) == crcdf_pkg::CharCr,
    cnt_q == '0 && crc_q == 16'h0000 && !start_ok_q, "frame state not cleared after end")
  `CRCDF_ASSERT_IMP(a_stall_needs_item, in_stall_o, s1_valid_q && out_valid_q,
    "input stalled without a pending request")

endmodule

`default_nettype wire
